>>> rtl/core/boundary_tag_first_fit_allocator_assert.svh
// assertion macros shared by the allocator rtl
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// condition holds in the same cycle
`define BTFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the following cycle
`define BTFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/btff_pkg.sv
// shared types and constants for the boundary tag allocator
package btff_pkg;

  localparam int HEAP_BYTES_DEF = 65536;
  localparam int CHUNK_W        = 17;
  localparam int TAG_W          = 32;
  localparam int XW             = 35;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_bytes;
    logic [15:0] free_address;
  } alloc_req_t;

  typedef struct packed {
    logic [15:0] block_address;
    logic [1:0]  status;
  } alloc_rsp_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LATCH, OP_CLR, OP_INIT0, OP_INIT1, OP_INIT2,
    OP_RD_HDR_BP, OP_RD_HDR_NB, OP_RD_HDR_PB, OP_RD_PRV, OP_RD_FP,
    OP_ADV, OP_EXT, OP_GROW,
    OP_W_HDR_BP, OP_W_FTR_BP, OP_W_HDR_NB, OP_W_FTR_NB, OP_W_HDR_PB, OP_W_EPI,
    OP_NB_T, OP_PB_T, OP_FP_T, OP_PA_T, OP_SZ_T, OP_NA_T, OP_MSUM,
    OP_CS_T, OP_CSET, OP_REM,
    OP_RES_OK, OP_RES_ZERO, OP_RES_OOM, OP_RES_FREE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic free_ok;
    logic bp_lt_brk;
    logic t_zero;
    logic t_fit;
    logic t_alloc;
    logic grow_fail;
    logic pa;
    logic na;
    logic split;
    logic clr_last;
  } dp_status_t;

  typedef enum logic [1:0] {MODE_INIT, MODE_ALLOC, MODE_FREE} mode_t;

  typedef enum logic [5:0] {
    S_CLR, S_INIT0, S_INIT1, S_INIT2, S_IDLE, S_DISP,
    S_FF_CHK, S_FF_EVAL, S_EXT,
    S_G0, S_G_RH, S_G_WF, S_G_RH2, S_G_NB, S_G_EPI,
    S_M_RPRV, S_M_PB, S_M_RPH, S_M_FP, S_M_RFP, S_M_PA, S_M_RH, S_M_SZ,
    S_M_RNH, S_M_NA, S_M_DEC,
    S_MA_WH, S_MA_RH, S_MA_WF, S_MB_RH, S_MB_WF, S_MB_WP,
    S_MC_WP, S_MC_RN, S_MC_WF, S_M_END,
    S_C_R, S_C_CS, S_C_SET, S_C_WH, S_C_RH, S_C_WF, S_C_RH2, S_C_NB,
    S_C_REM, S_C_WNH, S_C_RN, S_C_WNF,
    S_F_RD, S_F_CHK, S_F_WH, S_F_RH, S_F_WF,
    S_RES_OK, S_RES_ZERO, S_RES_OOM, S_RES_FREE
  } state_t;

endpackage

>>> rtl/core/btff_dpath.sv
// datapath: tag memory, block pointers, size arithmetic and result register
module btff_dpath #(
  parameter int HEAP_BYTES = btff_pkg::HEAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  btff_pkg::cmd_t               cmd,
  input  btff_pkg::alloc_req_t         req,
  input  logic [btff_pkg::CHUNK_W-1:0] chunk,
  output btff_pkg::dp_status_t         sts,
  output btff_pkg::alloc_rsp_t         result,
  output logic                         done
);

  localparam int STORE_WORDS = HEAP_BYTES / 4;
  localparam int IW          = $clog2(STORE_WORDS);
  localparam int XW          = btff_pkg::XW;
  localparam int TW          = btff_pkg::TAG_W;
  localparam int CW          = btff_pkg::CHUNK_W;
  localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);

  logic [TW-1:0] mem [STORE_WORDS];
  logic [TW-1:0] q;
  logic          oob;

  logic          opc;
  logic          reqz;
  logic [XW-1:0] bp, pb, nb, fp, brk;
  logic [TW-1:0] sz, psz, nsz, csize;
  logic          pa, na;
  logic [CW-1:0] asize, ext;
  logic [IW-1:0] cnt;

  logic [TW-1:0] t_val, tsz;
  logic [XW-1:0] tsize;
  logic [CW-1:0] asize_in;
  logic [17:0]   gsz;
  logic [15:0]   gwords;
  logic          split;

  logic          we, re;
  logic [XW-1:0] wa, ra;
  logic [TW-1:0] wd;

  // out-of-heap tags read as size zero, allocated
  assign t_val = oob ? TW'(1) : q;
  assign tsz   = {t_val[TW-1:3], 3'b000};
  assign tsize = XW'(tsz);

  assign asize_in = (req.request_bytes <= 16'd8) ? CW'(16)
                  : ((CW'(req.request_bytes) + CW'(15)) & ~CW'(7));
  assign gwords = (16'(ext[CW-1:2]) + 16'd1) & ~16'd1;
  assign gsz    = {gwords, 2'b00};
  assign split  = {1'b0, csize} >= (33'(asize) + 33'd16);

  always_comb begin
    sts.is_free   = opc;
    sts.req_zero  = reqz;
    sts.free_ok   = (bp[2:0] == 3'b000) && (bp >= XW'(16)) && (bp < brk);
    sts.bp_lt_brk = bp < brk;
    sts.t_zero    = tsz == '0;
    sts.t_fit     = !t_val[0] && (TW'(asize) <= tsz);
    sts.t_alloc   = t_val[0];
    sts.grow_fail = (brk + XW'(gsz)) > HEAP_X;
    sts.pa        = pa;
    sts.na        = na;
    sts.split     = split;
    sts.clr_last  = cnt == IW'(STORE_WORDS - 1);
  end

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = '0;
    ra = '0;
    wd = '0;
    unique case (cmd.op)
      btff_pkg::OP_CLR: begin
        we = 1'b1;
        wa = XW'({cnt, 2'b00});
      end
      btff_pkg::OP_INIT0: begin
        we = 1'b1; wa = XW'(4);  wd = TW'(9);
      end
      btff_pkg::OP_INIT1: begin
        we = 1'b1; wa = XW'(8);  wd = TW'(9);
      end
      btff_pkg::OP_INIT2: begin
        we = 1'b1; wa = XW'(12); wd = TW'(1);
      end
      btff_pkg::OP_RD_HDR_BP: begin re = 1'b1; ra = bp - XW'(4); end
      btff_pkg::OP_RD_HDR_NB: begin re = 1'b1; ra = nb - XW'(4); end
      btff_pkg::OP_RD_HDR_PB: begin re = 1'b1; ra = pb - XW'(4); end
      btff_pkg::OP_RD_PRV:    begin re = 1'b1; ra = bp - XW'(8); end
      btff_pkg::OP_RD_FP:     begin re = 1'b1; ra = fp; end
      btff_pkg::OP_GROW: begin
        we = 1'b1; wa = brk - XW'(4); wd = TW'(gsz);
      end
      btff_pkg::OP_W_HDR_BP: begin we = 1'b1; wa = bp - XW'(4); wd = sz; end
      btff_pkg::OP_W_FTR_BP: begin we = 1'b1; wa = bp + tsize - XW'(8); wd = sz; end
      btff_pkg::OP_W_HDR_NB: begin we = 1'b1; wa = nb - XW'(4); wd = sz; end
      btff_pkg::OP_W_FTR_NB: begin we = 1'b1; wa = nb + tsize - XW'(8); wd = sz; end
      btff_pkg::OP_W_HDR_PB: begin we = 1'b1; wa = pb - XW'(4); wd = sz; end
      btff_pkg::OP_W_EPI:    begin we = 1'b1; wa = nb - XW'(4); wd = TW'(1); end
      default: ;
    endcase
  end

  // tag memory, writes outside the heap are dropped
  always_ff @(posedge clk) begin
    if (we && (wa < HEAP_X)) begin
      mem[wa[IW+1:2]] <= wd;
    end
    if (re) begin
      oob <= !(ra < HEAP_X);
      if (ra < HEAP_X) begin
        q <= mem[ra[IW+1:2]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (cmd.op)
        btff_pkg::OP_LATCH: begin
          opc   <= req.opcode;
          reqz  <= req.request_bytes == 16'd0;
          asize <= asize_in;
          bp    <= (req.opcode == btff_pkg::OPC_FREE) ? XW'(req.free_address) : XW'(8);
        end
        btff_pkg::OP_CLR:   cnt <= cnt + IW'(1);
        btff_pkg::OP_INIT2: begin
          brk <= XW'(16);
          ext <= btff_pkg::CHUNK_RESET;
        end
        btff_pkg::OP_ADV: bp <= bp + tsize;
        btff_pkg::OP_EXT: ext <= (asize > chunk) ? asize : chunk;
        btff_pkg::OP_GROW: begin
          bp  <= brk;
          brk <= brk + XW'(gsz);
          sz  <= TW'(gsz);
        end
        btff_pkg::OP_W_HDR_PB: bp <= pb;
        btff_pkg::OP_NB_T: nb <= bp + tsize;
        btff_pkg::OP_PB_T: pb <= bp - tsize;
        btff_pkg::OP_FP_T: fp <= pb + tsize - XW'(8);
        btff_pkg::OP_PA_T: begin
          pa  <= t_val[0];
          psz <= tsz;
        end
        btff_pkg::OP_SZ_T: begin
          sz <= tsz;
          nb <= bp + tsize;
        end
        btff_pkg::OP_NA_T: begin
          na  <= t_val[0];
          nsz <= tsz;
        end
        btff_pkg::OP_MSUM: sz <= sz + (pa ? '0 : psz) + (na ? '0 : nsz);
        btff_pkg::OP_CS_T: csize <= tsz;
        btff_pkg::OP_CSET: sz <= split ? (TW'(asize) | TW'(1)) : (csize | TW'(1));
        btff_pkg::OP_REM:  sz <= csize - TW'(asize);
        btff_pkg::OP_RES_OK: begin
          result <= '{block_address: bp[15:0], status: btff_pkg::ST_OK};
          done   <= 1'b1;
        end
        btff_pkg::OP_RES_ZERO: begin
          result <= '{block_address: 16'd0, status: btff_pkg::ST_ZERO};
          done   <= 1'b1;
        end
        btff_pkg::OP_RES_OOM: begin
          result <= '{block_address: 16'd0, status: btff_pkg::ST_OOM};
          done   <= 1'b1;
        end
        btff_pkg::OP_RES_FREE: begin
          result <= '{block_address: 16'd0, status: btff_pkg::ST_OK};
          done   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/btff_ctrl.sv
// controller: sequences tag reads and writes for alloc, free, growth and merge
module btff_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  btff_pkg::dp_status_t sts,
  output btff_pkg::cmd_t       cmd,
  output logic                 busy
);

  btff_pkg::state_t state, state_next;
  btff_pkg::mode_t  mode, mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btff_pkg::S_CLR;
      mode  <= btff_pkg::MODE_INIT;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  assign busy = state != btff_pkg::S_IDLE;

  always_comb begin
    state_next = state;
    mode_next  = mode;
    cmd.op     = btff_pkg::OP_NOP;
    unique case (state)
      btff_pkg::S_CLR: begin
        cmd.op = btff_pkg::OP_CLR;
        if (sts.clr_last) state_next = btff_pkg::S_INIT0;
      end
      btff_pkg::S_INIT0: begin cmd.op = btff_pkg::OP_INIT0; state_next = btff_pkg::S_INIT1; end
      btff_pkg::S_INIT1: begin cmd.op = btff_pkg::OP_INIT1; state_next = btff_pkg::S_INIT2; end
      btff_pkg::S_INIT2: begin
        cmd.op     = btff_pkg::OP_INIT2;
        mode_next  = btff_pkg::MODE_INIT;
        state_next = btff_pkg::S_G0;
      end
      btff_pkg::S_IDLE: begin
        if (start) begin
          cmd.op     = btff_pkg::OP_LATCH;
          state_next = btff_pkg::S_DISP;
        end
      end
      btff_pkg::S_DISP: begin
        if (sts.is_free) begin
          mode_next  = btff_pkg::MODE_FREE;
          state_next = sts.free_ok ? btff_pkg::S_F_RD : btff_pkg::S_RES_FREE;
        end else begin
          mode_next  = btff_pkg::MODE_ALLOC;
          state_next = sts.req_zero ? btff_pkg::S_RES_ZERO : btff_pkg::S_FF_CHK;
        end
      end
      // first-fit walk, one header per read
      btff_pkg::S_FF_CHK: begin
        if (sts.bp_lt_brk) begin
          cmd.op     = btff_pkg::OP_RD_HDR_BP;
          state_next = btff_pkg::S_FF_EVAL;
        end else begin
          state_next = btff_pkg::S_EXT;
        end
      end
      btff_pkg::S_FF_EVAL: begin
        priority if (sts.t_zero) begin
          state_next = btff_pkg::S_EXT;
        end else if (sts.t_fit) begin
          state_next = btff_pkg::S_C_R;
        end else begin
          cmd.op     = btff_pkg::OP_ADV;
          state_next = btff_pkg::S_FF_CHK;
        end
      end
      btff_pkg::S_EXT: begin cmd.op = btff_pkg::OP_EXT; state_next = btff_pkg::S_G0; end
      btff_pkg::S_G0: begin
        if (sts.grow_fail) begin
          state_next = btff_pkg::S_RES_OOM;
        end else begin
          cmd.op     = btff_pkg::OP_GROW;
          state_next = btff_pkg::S_G_RH;
        end
      end
      btff_pkg::S_G_RH:  begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_G_WF; end
      btff_pkg::S_G_WF:  begin cmd.op = btff_pkg::OP_W_FTR_BP;  state_next = btff_pkg::S_G_RH2; end
      btff_pkg::S_G_RH2: begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_G_NB; end
      btff_pkg::S_G_NB:  begin cmd.op = btff_pkg::OP_NB_T;      state_next = btff_pkg::S_G_EPI; end
      btff_pkg::S_G_EPI: begin cmd.op = btff_pkg::OP_W_EPI;     state_next = btff_pkg::S_M_RPRV; end
      // coalesce with neighbours
      btff_pkg::S_M_RPRV: begin cmd.op = btff_pkg::OP_RD_PRV;    state_next = btff_pkg::S_M_PB; end
      btff_pkg::S_M_PB:   begin cmd.op = btff_pkg::OP_PB_T;      state_next = btff_pkg::S_M_RPH; end
      btff_pkg::S_M_RPH:  begin cmd.op = btff_pkg::OP_RD_HDR_PB; state_next = btff_pkg::S_M_FP; end
      btff_pkg::S_M_FP:   begin cmd.op = btff_pkg::OP_FP_T;      state_next = btff_pkg::S_M_RFP; end
      btff_pkg::S_M_RFP:  begin cmd.op = btff_pkg::OP_RD_FP;     state_next = btff_pkg::S_M_PA; end
      btff_pkg::S_M_PA:   begin cmd.op = btff_pkg::OP_PA_T;      state_next = btff_pkg::S_M_RH; end
      btff_pkg::S_M_RH:   begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_M_SZ; end
      btff_pkg::S_M_SZ:   begin cmd.op = btff_pkg::OP_SZ_T;      state_next = btff_pkg::S_M_RNH; end
      btff_pkg::S_M_RNH:  begin cmd.op = btff_pkg::OP_RD_HDR_NB; state_next = btff_pkg::S_M_NA; end
      btff_pkg::S_M_NA:   begin cmd.op = btff_pkg::OP_NA_T;      state_next = btff_pkg::S_M_DEC; end
      btff_pkg::S_M_DEC: begin
        priority if (sts.pa && sts.na) begin
          state_next = btff_pkg::S_M_END;
        end else if (sts.pa) begin
          cmd.op     = btff_pkg::OP_MSUM;
          state_next = btff_pkg::S_MA_WH;
        end else if (sts.na) begin
          cmd.op     = btff_pkg::OP_MSUM;
          state_next = btff_pkg::S_MB_RH;
        end else begin
          cmd.op     = btff_pkg::OP_MSUM;
          state_next = btff_pkg::S_MC_WP;
        end
      end
      btff_pkg::S_MA_WH: begin cmd.op = btff_pkg::OP_W_HDR_BP;  state_next = btff_pkg::S_MA_RH; end
      btff_pkg::S_MA_RH: begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_MA_WF; end
      btff_pkg::S_MA_WF: begin cmd.op = btff_pkg::OP_W_FTR_BP;  state_next = btff_pkg::S_M_END; end
      btff_pkg::S_MB_RH: begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_MB_WF; end
      btff_pkg::S_MB_WF: begin cmd.op = btff_pkg::OP_W_FTR_BP;  state_next = btff_pkg::S_MB_WP; end
      btff_pkg::S_MB_WP: begin cmd.op = btff_pkg::OP_W_HDR_PB;  state_next = btff_pkg::S_M_END; end
      btff_pkg::S_MC_WP: begin cmd.op = btff_pkg::OP_W_HDR_PB;  state_next = btff_pkg::S_MC_RN; end
      btff_pkg::S_MC_RN: begin cmd.op = btff_pkg::OP_RD_HDR_NB; state_next = btff_pkg::S_MC_WF; end
      btff_pkg::S_MC_WF: begin cmd.op = btff_pkg::OP_W_FTR_NB;  state_next = btff_pkg::S_M_END; end
      btff_pkg::S_M_END: begin
        unique case (mode)
          btff_pkg::MODE_INIT:  state_next = btff_pkg::S_IDLE;
          btff_pkg::MODE_FREE:  state_next = btff_pkg::S_RES_FREE;
          btff_pkg::MODE_ALLOC: state_next = btff_pkg::S_C_R;
          default:              state_next = btff_pkg::S_IDLE;
        endcase
      end
      // carve the chosen block, splitting off the remainder
      btff_pkg::S_C_R:   begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_C_CS; end
      btff_pkg::S_C_CS:  begin cmd.op = btff_pkg::OP_CS_T;      state_next = btff_pkg::S_C_SET; end
      btff_pkg::S_C_SET: begin cmd.op = btff_pkg::OP_CSET;      state_next = btff_pkg::S_C_WH; end
      btff_pkg::S_C_WH:  begin cmd.op = btff_pkg::OP_W_HDR_BP;  state_next = btff_pkg::S_C_RH; end
      btff_pkg::S_C_RH:  begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_C_WF; end
      btff_pkg::S_C_WF: begin
        cmd.op     = btff_pkg::OP_W_FTR_BP;
        state_next = sts.split ? btff_pkg::S_C_RH2 : btff_pkg::S_RES_OK;
      end
      btff_pkg::S_C_RH2: begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_C_NB; end
      btff_pkg::S_C_NB:  begin cmd.op = btff_pkg::OP_NB_T;      state_next = btff_pkg::S_C_REM; end
      btff_pkg::S_C_REM: begin cmd.op = btff_pkg::OP_REM;       state_next = btff_pkg::S_C_WNH; end
      btff_pkg::S_C_WNH: begin cmd.op = btff_pkg::OP_W_HDR_NB;  state_next = btff_pkg::S_C_RN; end
      btff_pkg::S_C_RN:  begin cmd.op = btff_pkg::OP_RD_HDR_NB; state_next = btff_pkg::S_C_WNF; end
      btff_pkg::S_C_WNF: begin cmd.op = btff_pkg::OP_W_FTR_NB;  state_next = btff_pkg::S_RES_OK; end
      // free: clear the allocated bit, then merge
      btff_pkg::S_F_RD: begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_F_CHK; end
      btff_pkg::S_F_CHK: begin
        if (sts.t_alloc) begin
          cmd.op     = btff_pkg::OP_SZ_T;
          state_next = btff_pkg::S_F_WH;
        end else begin
          state_next = btff_pkg::S_RES_FREE;
        end
      end
      btff_pkg::S_F_WH: begin cmd.op = btff_pkg::OP_W_HDR_BP;  state_next = btff_pkg::S_F_RH; end
      btff_pkg::S_F_RH: begin cmd.op = btff_pkg::OP_RD_HDR_BP; state_next = btff_pkg::S_F_WF; end
      btff_pkg::S_F_WF: begin cmd.op = btff_pkg::OP_W_FTR_BP;  state_next = btff_pkg::S_M_RPRV; end
      btff_pkg::S_RES_OK:   begin cmd.op = btff_pkg::OP_RES_OK;   state_next = btff_pkg::S_IDLE; end
      btff_pkg::S_RES_ZERO: begin cmd.op = btff_pkg::OP_RES_ZERO; state_next = btff_pkg::S_IDLE; end
      btff_pkg::S_RES_OOM:  begin cmd.op = btff_pkg::OP_RES_OOM;  state_next = btff_pkg::S_IDLE; end
      btff_pkg::S_RES_FREE: begin cmd.op = btff_pkg::OP_RES_FREE; state_next = btff_pkg::S_IDLE; end
      default: state_next = btff_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/boundary_tag_first_fit_allocator.sv
// from acceptance to result: a zero-size alloc is answered directly, a free checks the header and merges,
// an alloc walks the headers first fit, may grow the heap and merge, and may split off a remainder
// one item at a time, busy until the result
// reset: synchronous; a clearing pass over every tag word, then the initial heap is built,
// during which busy is high; results cannot be stalled by the receiver
`include "boundary_tag_first_fit_allocator_assert.svh"

module boundary_tag_first_fit_allocator #(
  parameter int HEAP_BYTES = btff_pkg::HEAP_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  btff_pkg::alloc_req_t request,
  output logic                 done,
  output btff_pkg::alloc_rsp_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [btff_pkg::CHUNK_W-1:0] chunk;
  btff_pkg::cmd_t               cmd;
  btff_pkg::dp_status_t         sts;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(chunk);

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= btff_pkg::CHUNK_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      chunk <= pwdata[btff_pkg::CHUNK_W-1:0];
    end
  end

  btff_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  btff_dpath #(.HEAP_BYTES(HEAP_BYTES)) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (request),
    .chunk  (chunk),
    .sts    (sts),
    .result (result),
    .done   (done)
  );

  `BTFF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `BTFF_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")
  `BTFF_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
  `BTFF_ASSERT_NOW(a_status_code, done, result.status != 2'd3, "undefined status code")

endmodule
